[rtl/tsba_pkg.sv]
// ----------------------------------------------------------------------------
// tsba_pkg
// Shared types and constants of the tile slot bitmap allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package tsba_pkg;

    localparam int DEF_BITMAP_WORDS  = 5;
    localparam int DEF_OWNER_ENTRIES = 256;

    localparam int WORD_W        = 16;
    localparam int SLOT_W        = 8;
    localparam int OFFSET_W      = 7;
    localparam int OWNER_INDEX_W = 9;
    localparam int REQ_W         = 3;

    localparam logic [SLOT_W-1:0] SLOT_BASE    = 8'd48;
    localparam logic [SLOT_W-1:0] SLOT_FAIL    = 8'd128;
    localparam logic [SLOT_W-1:0] RESERVE_FROM = 8'd64;
    localparam logic [SLOT_W-1:0] OWNER_NONE   = 8'hff;
    localparam logic [WORD_W-1:0] NIBBLE       = 16'h000f;
    localparam logic [WORD_W-1:0] WORD_ALL     = 16'hffff;

    localparam logic [REQ_W-1:0] REQ_ALLOC_ONE   = 3'd0;
    localparam logic [REQ_W-1:0] REQ_ALLOC_GROUP = 3'd1;
    localparam logic [REQ_W-1:0] REQ_RELEASE     = 3'd2;
    localparam logic [REQ_W-1:0] REQ_RESERVE     = 3'd3;
    localparam logic [REQ_W-1:0] REQ_UNRESERVE   = 3'd4;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC
    } state_t;

    // outcome of a free slot search: offset is word * 16 + bit
    typedef struct packed {
        logic                found;
        logic [OFFSET_W-1:0] offset;
    } find_t;

endpackage

`default_nettype wire

[rtl/tile_slot_bitmap_allocator.sv]
// ----------------------------------------------------------------------------
// tile_slot_bitmap_allocator
// Bitmap free list of tile slots with an owner table and a reservation mode.
// ----------------------------------------------------------------------------
// The accept cycle of a request reads the owner table entry; the next cycle
// searches the free bitmap, writes back bitmap and owner entry and loads the
// result register, and no new request is taken before that. The owner table
// is a synchronous memory with one write and one read port; after reset all
// OWNER_ENTRIES entries (256 by default) are swept to the invalid mark, one
// entry per cycle, and in_stall stays high until the sweep is done. Slots run
// from 48 up; a failed allocation answers 128 and sets alloc_failed if no slot is 128.
`default_nettype none

module tile_slot_bitmap_allocator
    import tsba_pkg::*;
#(
    parameter int BITMAP_WORDS  = DEF_BITMAP_WORDS,
    parameter int OWNER_ENTRIES = DEF_OWNER_ENTRIES
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,

    input  wire logic                     in_valid,
    output logic                          in_stall,
    input  wire logic [REQ_W-1:0]         req_type,
    input  wire logic [OWNER_INDEX_W-1:0] owner_index,
    input  wire logic                     group_release,

    output logic                          out_valid,
    input  wire logic                     out_stall,
    output logic [SLOT_W-1:0]             slot_number,
    output logic                          alloc_failed
);

    localparam int   WIDX_W      = (BITMAP_WORDS > 1) ? $clog2(BITMAP_WORDS) : 1;
    localparam int   OIDX_W      = $clog2(OWNER_ENTRIES);
    localparam int   SLOT_TOP    = 48 + 16 * BITMAP_WORDS;
    localparam logic FAIL_FLAG   = (SLOT_TOP <= 128) ? 1'b1 : 1'b0;
    localparam logic [10:0] OWNER_LIMIT = 11'(OWNER_ENTRIES);

    state_t state_reg, state_next;
    logic [OIDX_W-1:0] clr_cnt_reg, clr_cnt_next;

    logic [BITMAP_WORDS-1:0][WORD_W-1:0] bitmap_reg, bitmap_next;
    logic reserved_reg, reserved_next;

    logic [REQ_W-1:0]         req_reg;
    logic [OWNER_INDEX_W-1:0] owner_reg;
    logic                     group_reg;

    logic              out_valid_reg;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic              failed_reg, failed_next;

    logic [SLOT_W-1:0] owner_mem [OWNER_ENTRIES];
    logic [SLOT_W-1:0] mem_rd_reg;
    logic              mem_we;
    logic [OIDX_W-1:0] mem_waddr;
    logic [SLOT_W-1:0] mem_wdata;
    logic              exec_we;
    logic [SLOT_W-1:0] exec_wdata;

    logic accept;
    find_t find;

    logic              owner_ok;
    logic [SLOT_W-1:0] rel_off;
    logic              rel_in_range;
    logic              rel_blocked;
    logic [WIDX_W-1:0] rel_word;
    logic [WIDX_W-1:0] find_word;
    logic [WORD_W-1:0] find_mask;
    logic [WORD_W-1:0] rel_mask;

    tsba_slot_find #(
        .BITMAP_WORDS (BITMAP_WORDS)
    ) u_find (
        .words  (bitmap_reg),
        .group  (req_reg == REQ_ALLOC_GROUP),
        .result (find)
    );

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            bitmap_reg    <= {BITMAP_WORDS{WORD_ALL}};
            reserved_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            bitmap_reg    <= bitmap_next;
            reserved_reg  <= reserved_next;
            out_valid_reg <= (state_reg == ST_EXEC) || (out_valid_reg && out_stall);
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        in_stall     = 1'b1;
        mem_we       = 1'b0;
        mem_waddr    = clr_cnt_reg;
        mem_wdata    = OWNER_NONE;
        case (state_reg)
            ST_CLEAR:
            begin
                mem_we       = 1'b1;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == OIDX_W'(OWNER_ENTRIES - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_stall = out_valid_reg && out_stall;
                if (in_valid && !in_stall)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                mem_we     = exec_we;
                mem_waddr  = OIDX_W'(owner_reg);
                mem_wdata  = exec_wdata;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign accept = in_valid && !in_stall;

    // request beat capture
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg   <= req_type;
            owner_reg <= owner_index;
            group_reg <= group_release;
        end
        if (state_reg == ST_EXEC)
        begin
            slot_reg   <= slot_next;
            failed_reg <= failed_next;
        end
    end

    // owner table
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            owner_mem[mem_waddr] <= mem_wdata;
        end
        mem_rd_reg <= owner_mem[OIDX_W'(owner_index)];
    end

    // read-modify-write datapath of the execute cycle
    always_comb
    begin
        owner_ok     = {2'b00, owner_reg} < OWNER_LIMIT;
        rel_off      = mem_rd_reg - SLOT_BASE;
        rel_in_range = (mem_rd_reg >= SLOT_BASE) && ({1'b0, mem_rd_reg} < 9'(SLOT_TOP));
        rel_blocked  = reserved_reg && (mem_rd_reg >= RESERVE_FROM);
        rel_word     = rel_off[WIDX_W+3:4];
        rel_mask     = group_reg ? (NIBBLE << rel_off[3:0])
                                 : (16'h0001 << rel_off[3:0]);
        find_word    = find.offset[WIDX_W+3:4];
        find_mask    = (req_reg == REQ_ALLOC_GROUP) ? (NIBBLE << find.offset[3:0])
                                                    : (16'h0001 << find.offset[3:0]);

        bitmap_next   = bitmap_reg;
        reserved_next = reserved_reg;
        slot_next     = '0;
        failed_next   = 1'b0;
        exec_we       = 1'b0;
        exec_wdata    = OWNER_NONE;

        if (state_reg == ST_EXEC)
        begin
            case (req_reg)
                REQ_ALLOC_ONE, REQ_ALLOC_GROUP:
                begin
                    if (find.found)
                    begin
                        bitmap_next[find_word] = bitmap_reg[find_word] & ~find_mask;
                        slot_next = SLOT_BASE + SLOT_W'(find.offset);
                    end
                    else
                    begin
                        // with a pool reaching past 127 the fail code looks like a slot
                        slot_next   = SLOT_FAIL;
                        failed_next = FAIL_FLAG;
                    end
                    exec_we    = owner_ok && !failed_next;
                    exec_wdata = slot_next;
                end
                REQ_RELEASE:
                begin
                    if (owner_ok && rel_in_range)
                    begin
                        if (!rel_blocked)
                        begin
                            bitmap_next[rel_word] = bitmap_reg[rel_word] | rel_mask;
                        end
                        exec_we = 1'b1;
                    end
                end
                REQ_RESERVE:
                begin
                    reserved_next = 1'b1;
                    for (int w = 1; w < BITMAP_WORDS; w++)
                    begin
                        bitmap_next[w] = '0;
                    end
                end
                REQ_UNRESERVE:
                begin
                    reserved_next = 1'b0;
                    for (int w = 1; w < BITMAP_WORDS; w++)
                    begin
                        bitmap_next[w] = WORD_ALL;
                    end
                end
                default:
                begin
                    slot_next = '0;
                end
            endcase
        end
    end

    assign out_valid    = out_valid_reg;
    assign slot_number  = slot_reg;
    assign alloc_failed = failed_reg;

endmodule

`default_nettype wire

[rtl/tsba_slot_find.sv]
// ----------------------------------------------------------------------------
// tsba_slot_find
// Finds the lowest free bit, or the lowest fully free aligned nibble, in the
// first word of the free bitmap that has one.
// ----------------------------------------------------------------------------
`default_nettype none

module tsba_slot_find
    import tsba_pkg::*;
#(
    parameter int BITMAP_WORDS = DEF_BITMAP_WORDS
)
(
    input  wire logic [BITMAP_WORDS-1:0][WORD_W-1:0] words,
    input  wire logic                                group,
    output find_t                                    result
);

    localparam int WIDX_W = (BITMAP_WORDS > 1) ? $clog2(BITMAP_WORDS) : 1;

    logic [BITMAP_WORDS-1:0][WORD_W-1:0] cand;
    logic [BITMAP_WORDS-1:0]             hit;
    logic [BITMAP_WORDS-1:0][3:0]        low_bit;
    logic [WIDX_W-1:0]                   sel;

    always_comb
    begin
        for (int w = 0; w < BITMAP_WORDS; w++)
        begin
            // a group candidate is marked at the nibble's lowest bit
            cand[w] = '0;
            if (group)
            begin
                for (int n = 0; n < WORD_W / 4; n++)
                begin
                    cand[w][n*4] = &words[w][n*4 +: 4];
                end
            end
            else
            begin
                cand[w] = words[w];
            end
            hit[w] = |cand[w];
            low_bit[w] = '0;
            for (int i = WORD_W - 1; i >= 0; i--)
            begin
                if (cand[w][i])
                begin
                    low_bit[w] = 4'(i);
                end
            end
        end

        sel = '0;
        for (int w = BITMAP_WORDS - 1; w >= 0; w--)
        begin
            if (hit[w])
            begin
                sel = WIDX_W'(w);
            end
        end

        result.found  = |hit;
        result.offset = OFFSET_W'({sel, low_bit[sel]});
    end

endmodule

`default_nettype wire
